### src/flg_pkg.sv
`default_nettype none
package flg_pkg;

  // Block sizing
  localparam int DELAY_DEPTH    = 512;
  localparam int COS_TABLE_BITS = 10;
  localparam int PHASE_BITS     = 32;

  localparam int ADDR_W     = $clog2(DELAY_DEPTH);
  localparam int PTR_EXT_W  = ADDR_W + 1;
  localparam int FILL_W     = $clog2(DELAY_DEPTH + 1);
  localparam int QTR_BITS   = COS_TABLE_BITS - 2;
  localparam int QTR_SIZE   = 1 << QTR_BITS;
  localparam int T_SHIFT    = 18 - COS_TABLE_BITS;

  // Datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int DEPTH_W    = 17;
  localparam int MAXD_W     = 9;
  localparam int HALF_W     = MAXD_W - 1;
  localparam int SWING_W    = 31;
  localparam int MPROD_W    = 34;
  localparam int PROD_W     = HALF_W + SWING_W;
  localparam int RAWD_W     = PROD_W - 30;
  localparam int DLY_SUM_W  = RAWD_W + 1;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  localparam logic [DEPTH_W-1:0] DEPTH_ONE = DEPTH_W'(32768);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LFO_STEP  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MOD_DEPTH = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY = CFG_IDX_W'(3);

  // Quarter-wave polynomial, Q30
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam longint POLY_C1 = 64'sd1324675879;
  localparam longint POLY_C2 = 64'sd272375560;
  localparam longint POLY_C3 = 64'sd22401994;
  localparam longint POLY_C4 = 64'sd987050;

  typedef logic [14:0] qcos_t;
  typedef qcos_t qtab_t [QTR_SIZE];

  // cos(pi*t/2), t in Q16; elaboration only
  function automatic qcos_t quarter_cos(input longint t);
    longint s;
    longint acc;
    longint p;
    s   = (t * t) >>> 2;
    acc = POLY_C4;
    p = (s * acc) >>> 30; acc = POLY_C3 - p; if (acc < 0) acc = 0;
    p = (s * acc) >>> 30; acc = POLY_C2 - p; if (acc < 0) acc = 0;
    p = (s * acc) >>> 30; acc = POLY_C1 - p; if (acc < 0) acc = 0;
    p = (s * acc) >>> 30; acc = ONE_Q30 - p; if (acc < 0) acc = 0;
    acc = (acc + 16384) >>> 15;
    if (acc > 32767) acc = 32767;
    return qcos_t'(acc);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t tab;
    for (int i = 0; i < QTR_SIZE; i++) begin
      tab[i] = quarter_cos(longint'(i) << T_SHIFT);
    end
    return tab;
  endfunction

  localparam qtab_t QCOS_TAB = build_qtab();
  localparam qcos_t QCOS_END = quarter_cos(longint'(QTR_SIZE) << T_SHIFT);

  // Sequencer <-> datapath
  typedef struct packed {
    logic take_in;
    logic ld_cos;
    logic ld_swing;
    logic ld_delay;
    logic rd_mem;
    logic out_mix;
    logic out_pass;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic enable;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

### src/flg_seq.sv
`default_nettype none
module flg_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire flg_pkg::stat_t stat_i,
  output flg_pkg::ctrl_t      ctrl_o
);

  typedef logic [2:0] upc_t;

  typedef enum logic [1:0] {
    JC_NONE     = 2'd0,
    JC_WAIT_IN  = 2'd1,
    JC_DISABLED = 2'd2,
    JC_OUT_BUSY = 2'd3
  } jc_e;

  typedef struct packed {
    flg_pkg::ctrl_t ctl;
    jc_e            jc;
    upc_t           tgt;
    upc_t           nxt;
  } uword_t;

  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_COS   = 3'd1;
  localparam upc_t UPC_SWING = 3'd2;
  localparam upc_t UPC_DELAY = 3'd3;
  localparam upc_t UPC_READ  = 3'd4;
  localparam upc_t UPC_MIX   = 3'd5;
  localparam upc_t UPC_PASS  = 3'd6;

  localparam flg_pkg::ctrl_t C_NOP = '0;

  // Control store
  function automatic uword_t ucode(input upc_t a);
    uword_t w;
    w = '{ctl: C_NOP, jc: JC_NONE, tgt: UPC_IDLE, nxt: UPC_IDLE};
    case (a)
      UPC_IDLE: begin
        w.ctl.take_in = 1'b1;
        w.jc  = JC_WAIT_IN;
        w.tgt = UPC_IDLE;
        w.nxt = UPC_COS;
      end
      UPC_COS: begin
        w.ctl.ld_cos = 1'b1;
        w.jc  = JC_DISABLED;
        w.tgt = UPC_PASS;
        w.nxt = UPC_SWING;
      end
      UPC_SWING: begin
        w.ctl.ld_swing = 1'b1;
        w.nxt = UPC_DELAY;
      end
      UPC_DELAY: begin
        w.ctl.ld_delay = 1'b1;
        w.nxt = UPC_READ;
      end
      UPC_READ: begin
        w.ctl.rd_mem = 1'b1;
        w.nxt = UPC_MIX;
      end
      UPC_MIX: begin
        w.ctl.out_mix = 1'b1;
        w.jc  = JC_OUT_BUSY;
        w.tgt = UPC_MIX;
        w.nxt = UPC_IDLE;
      end
      UPC_PASS: begin
        w.ctl.out_pass = 1'b1;
        w.jc  = JC_OUT_BUSY;
        w.tgt = UPC_PASS;
        w.nxt = UPC_IDLE;
      end
      default: begin
        w.nxt = UPC_IDLE;
      end
    endcase
    return w;
  endfunction

  upc_t   upc_q, upc_d;
  uword_t word;
  logic   take_jump;

  assign word = ucode(upc_q);

  always_comb begin
    case (word.jc)
      JC_WAIT_IN:  take_jump = ~stat_i.in_valid;
      JC_DISABLED: take_jump = ~stat_i.enable;
      JC_OUT_BUSY: take_jump = ~stat_i.out_free;
      default:     take_jump = 1'b0;
    endcase
    upc_d = take_jump ? word.tgt : word.nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctrl_o = word.ctl;

endmodule
`default_nettype wire

### src/flg_cos.sv
`default_nettype none
module flg_cos (
  input  wire logic                            clk_i,
  input  wire logic                            ld_i,
  input  wire logic [flg_pkg::PHASE_BITS-1:0]  phase_i,
  output logic signed [flg_pkg::SAMPLE_W-1:0]  cos_o
);

  logic [flg_pkg::COS_TABLE_BITS-1:0] k;
  logic [1:0]                         quad;
  logic [flg_pkg::QTR_BITS-1:0]       r;
  logic [flg_pkg::QTR_BITS-1:0]       r_mir;
  flg_pkg::qcos_t                     mag;
  logic [flg_pkg::SAMPLE_W-1:0]       mag_x;
  logic [flg_pkg::SAMPLE_W-1:0]       cos_d;

  assign k     = phase_i[flg_pkg::PHASE_BITS-1 -: flg_pkg::COS_TABLE_BITS];
  assign quad  = k[flg_pkg::COS_TABLE_BITS-1 -: 2];
  assign r     = k[flg_pkg::QTR_BITS-1:0];
  assign r_mir = ~r + flg_pkg::QTR_BITS'(1);

  always_comb begin
    // odd quadrants read the quarter wave mirrored; r == 0 maps past the table
    if (quad[0]) begin
      mag = (r == '0) ? flg_pkg::QCOS_END : flg_pkg::QCOS_TAB[r_mir];
    end else begin
      mag = flg_pkg::QCOS_TAB[r];
    end
    mag_x = {1'b0, mag};
    cos_d = (quad[1] ^ quad[0]) ? (~mag_x + flg_pkg::SAMPLE_W'(1)) : mag_x;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      cos_o <= signed'(cos_d);
    end
  end

endmodule
`default_nettype wire

### src/flg_dline.sv
`default_nettype none
module flg_dline (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 wr_en_i,
  input  wire logic signed [flg_pkg::SAMPLE_W-1:0]  wr_data_i,
  input  wire logic                                 rd_en_i,
  input  wire logic [flg_pkg::ADDR_W-1:0]           delay_i,
  output logic signed [flg_pkg::SAMPLE_W-1:0]       rd_data_o
);

  logic [flg_pkg::SAMPLE_W-1:0] mem [flg_pkg::DELAY_DEPTH];

  logic [flg_pkg::ADDR_W-1:0]    wp_q, wp_d;
  logic [flg_pkg::FILL_W-1:0]    fill_q, fill_d;
  logic [flg_pkg::PTR_EXT_W-1:0] rd_sum;
  logic [flg_pkg::ADDR_W-1:0]    rd_addr;
  logic                          hit_q;
  logic [flg_pkg::SAMPLE_W-1:0]  rdata_q;

  always_comb begin
    wp_d   = (wp_q == flg_pkg::ADDR_W'(flg_pkg::DELAY_DEPTH - 1)) ? '0
             : wp_q + flg_pkg::ADDR_W'(1);
    fill_d = (fill_q == flg_pkg::FILL_W'(flg_pkg::DELAY_DEPTH)) ? fill_q
             : fill_q + flg_pkg::FILL_W'(1);
    // wp_q already points past the newest sample
    rd_sum = flg_pkg::PTR_EXT_W'(wp_q) + flg_pkg::PTR_EXT_W'(flg_pkg::DELAY_DEPTH - 1)
             - flg_pkg::PTR_EXT_W'(delay_i);
    if (rd_sum >= flg_pkg::PTR_EXT_W'(flg_pkg::DELAY_DEPTH)) begin
      rd_addr = flg_pkg::ADDR_W'(rd_sum - flg_pkg::PTR_EXT_W'(flg_pkg::DELAY_DEPTH));
    end else begin
      rd_addr = flg_pkg::ADDR_W'(rd_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
      hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        wp_q   <= wp_d;
        fill_q <= fill_d;
      end
      if (rd_en_i) begin
        // entries never written read as zero
        hit_q <= (flg_pkg::FILL_W'(delay_i) < fill_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wp_q] <= wr_data_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign rd_data_o = hit_q ? signed'(rdata_q) : '0;

endmodule
`default_nettype wire

### src/lfo_flanger.sv
`default_nettype none
// Flanger, one output transaction per input transaction.
// Enabled: the microcode steps COS, SWING, DELAY and READ, then MIX loads the output.
// Disabled (pass-through): COS, then PASS loads the output with the source sample.
// A new input is taken only back at IDLE; output back-pressure holds the sequencer at MIX/PASS.
// rst_ni (async, active low) clears config, LFO phase, write pointer, fill count.
module lfo_flanger (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration writes
  input  wire logic                                   cfg_we_i,
  input  wire logic [flg_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [flg_pkg::CFG_DATA_W-1:0]         cfg_data_i,
  // input channel
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic signed [flg_pkg::SAMPLE_W-1:0]    processed_sample_i,
  input  wire logic signed [flg_pkg::SAMPLE_W-1:0]    source_sample_i,
  // output channel
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [flg_pkg::SAMPLE_W-1:0]         out_sample_o
);

  // ------------------------------------------------------------------
  // Configuration registers
  // ------------------------------------------------------------------
  logic                               enable_q;
  logic [31:0]                        lfo_step_q;
  logic [15:0]                        mod_depth_q;
  logic [flg_pkg::MAXD_W-1:0]         max_delay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q    <= 1'b0;
      lfo_step_q  <= '0;
      mod_depth_q <= '0;
      max_delay_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        flg_pkg::CFG_ENABLE:    enable_q    <= cfg_data_i[0];
        flg_pkg::CFG_LFO_STEP:  lfo_step_q  <= cfg_data_i[31:0];
        flg_pkg::CFG_MOD_DEPTH: mod_depth_q <= cfg_data_i[15:0];
        flg_pkg::CFG_MAX_DELAY: max_delay_q <= cfg_data_i[flg_pkg::MAXD_W-1:0];
        default: ;  // unknown index: dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Sequencer: microcode ROM walks IDLE -> COS -> SWING -> DELAY ->
  // READ -> MIX, or IDLE -> COS -> PASS when disabled.
  // ------------------------------------------------------------------
  flg_pkg::ctrl_t ctrl;
  flg_pkg::stat_t stat;
  logic           in_acc;
  logic           out_free;
  logic           out_ld_mix;
  logic           out_ld_pass;

  assign in_stall_o  = ~ctrl.take_in;
  assign in_acc      = in_valid_i & ctrl.take_in;
  // output register can take a new value if empty or draining this cycle
  assign out_free    = ~out_valid_o | ~out_stall_i;
  assign out_ld_mix  = ctrl.out_mix & out_free;
  assign out_ld_pass = ctrl.out_pass & out_free;

  assign stat.in_valid = in_valid_i;
  assign stat.enable   = enable_q;
  assign stat.out_free = out_free;

  flg_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // ------------------------------------------------------------------
  // Input capture
  // ------------------------------------------------------------------
  logic signed [flg_pkg::SAMPLE_W-1:0] proc_q;
  logic signed [flg_pkg::SAMPLE_W-1:0] src_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      proc_q <= processed_sample_i;
      src_q  <= source_sample_i;
    end
  end

  // ------------------------------------------------------------------
  // LFO phase and cosine lookup
  // ------------------------------------------------------------------
  logic [flg_pkg::PHASE_BITS-1:0]      phase_q;
  logic signed [flg_pkg::SAMPLE_W-1:0] cos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (out_ld_mix) begin
      // phase only moves on flanged samples; wraps mod 2^PHASE_BITS
      phase_q <= phase_q + lfo_step_q[flg_pkg::PHASE_BITS-1:0];
    end
  end

  flg_cos u_cos (
    .clk_i   (clk_i),
    .ld_i    (ctrl.ld_cos),
    .phase_i (phase_q),
    .cos_o   (cos_q)
  );

  // ------------------------------------------------------------------
  // Swing: 2^30 - depth*cos. Depth saturates at one (Q15).
  // Result always lies in (0, 2^31).
  // ------------------------------------------------------------------
  logic [flg_pkg::DEPTH_W-1:0]          depth_sat;
  logic signed [flg_pkg::DEPTH_W:0]     depth_s;
  logic signed [flg_pkg::MPROD_W-1:0]   m_full;
  logic signed [flg_pkg::MPROD_W-1:0]   swing_full;
  logic [flg_pkg::SWING_W-1:0]          swing_q;

  assign depth_sat  = ({1'b0, mod_depth_q} > flg_pkg::DEPTH_ONE) ? flg_pkg::DEPTH_ONE
                      : {1'b0, mod_depth_q};
  assign depth_s    = signed'({1'b0, depth_sat});
  assign m_full     = depth_s * cos_q;
  assign swing_full = flg_pkg::MPROD_W'(flg_pkg::ONE_Q30) - m_full;

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_swing) begin
      swing_q <= swing_full[flg_pkg::SWING_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Delay: 1 + floor(half * swing / 2^30), capped at DELAY_DEPTH-1
  // ------------------------------------------------------------------
  logic [flg_pkg::HALF_W-1:0]    half;
  logic [flg_pkg::PROD_W-1:0]    prod;
  logic [flg_pkg::DLY_SUM_W-1:0] dly_sum;
  logic [flg_pkg::ADDR_W-1:0]    delay_q;

  assign half    = max_delay_q[flg_pkg::MAXD_W-1:1];
  assign prod    = flg_pkg::PROD_W'(half) * flg_pkg::PROD_W'(swing_q);
  assign dly_sum = flg_pkg::DLY_SUM_W'(prod[flg_pkg::PROD_W-1 -: flg_pkg::RAWD_W])
                   + flg_pkg::DLY_SUM_W'(1);

  always_ff @(posedge clk_i) begin
    if (ctrl.ld_delay) begin
      if (int'(dly_sum) > flg_pkg::DELAY_DEPTH - 1) begin
        delay_q <= flg_pkg::ADDR_W'(flg_pkg::DELAY_DEPTH - 1);
      end else begin
        delay_q <= flg_pkg::ADDR_W'(dly_sum);
      end
    end
  end

  // ------------------------------------------------------------------
  // Delay line: written on every accepted transaction, read at READ
  // ------------------------------------------------------------------
  logic signed [flg_pkg::SAMPLE_W-1:0] dly_sample;

  flg_dline u_dline (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc),
    .wr_data_i (source_sample_i),
    .rd_en_i   (ctrl.rd_mem),
    .delay_i   (delay_q),
    .rd_data_o (dly_sample)
  );

  // ------------------------------------------------------------------
  // Mix: (processed + delayed) / 2, truncated toward zero
  // ------------------------------------------------------------------
  logic [flg_pkg::SAMPLE_W:0]   mix_sum;
  logic [flg_pkg::SAMPLE_W:0]   mix_adj;
  logic [flg_pkg::SAMPLE_W-1:0] mix;

  assign mix_sum = {proc_q[flg_pkg::SAMPLE_W-1], proc_q}
                   + {dly_sample[flg_pkg::SAMPLE_W-1], dly_sample};
  // bias negative sums by one so the shift rounds toward zero
  assign mix_adj = mix_sum + (flg_pkg::SAMPLE_W + 1)'(mix_sum[flg_pkg::SAMPLE_W]);
  assign mix     = mix_adj[flg_pkg::SAMPLE_W:1];

  // ------------------------------------------------------------------
  // Output register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_ld_mix | out_ld_pass) begin
      out_valid_o <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld_mix) begin
      out_sample_o <= signed'(mix);
    end else if (out_ld_pass) begin
      out_sample_o <= src_q;
    end
  end

endmodule
`default_nettype wire

### src/flg_checker.sv
`default_nettype none
module flg_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_stall_o,
  input wire logic                                out_valid_o,
  input wire logic                                out_stall_i,
  input wire logic signed [flg_pkg::SAMPLE_W-1:0] out_sample_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_sample_o)))
    else $error("stalled output changed");

  // one sample in flight: input stalls right after a transaction
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while busy");

  // no result can appear in the cycle right after an input transaction
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_valid_o) |=> !out_valid_o)
    else $error("result too early");

  // a fresh result means the sequencer is back at idle
  a_idle_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_stall_o)
    else $error("result without return to idle");

endmodule

bind lfo_flanger flg_checker u_flg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .out_sample_o (out_sample_o)
);
`default_nettype wire
